/* design/gpbm_pkg.sv */
// Shared constants, payload types and helpers of the glob blocklist match unit.
`timescale 1ns / 1ps
package gpbm_pkg;

  localparam int PATTERN_SLOTS = 32;
  localparam int PATTERN_LEN   = 32;
  localparam int NAME_LEN      = 64;

  localparam int SI_W  = $clog2(PATTERN_SLOTS);
  localparam int CNT_W = $clog2(PATTERN_SLOTS + 1);
  localparam int PI_W  = $clog2(PATTERN_LEN);
  localparam int PL_W  = $clog2(PATTERN_LEN + 1);
  localparam int PA_W  = $clog2(PATTERN_SLOTS * PATTERN_LEN);
  localparam int NI_W  = $clog2(NAME_LEN);
  localparam int NL_W  = $clog2(NAME_LEN + 1);

  localparam logic [1:0] OP_PATTERN = 2'd0;
  localparam logic [1:0] OP_CLEAR   = 2'd1;
  localparam logic [1:0] OP_PATH    = 2'd2;

  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_QUEST  = 8'h3F;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] ch;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic blocked;
    logic name_overflow;
    logic pattern_dropped;
  } out_item_t;

  typedef struct packed {
    logic            en;
    logic [SI_W-1:0] slot;
    logic [PI_W-1:0] idx;
    logic [7:0]      data;
  } pat_wr_t;

  typedef struct packed {
    logic [SI_W-1:0] slot;
    logic [PI_W-1:0] idx;
  } pat_rd_t;

  typedef struct packed {
    logic            en;
    logic [SI_W-1:0] slot;
    logic [PL_W-1:0] len;
  } len_wr_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic hit;
  } seq_status_t;

  // Lowers ASCII A-Z when folding is enabled.
  function automatic logic [7:0] fold(input logic [7:0] c, input logic en);
    logic [7:0] r;
    r = c;
    if (en && c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

/* design/gpbm_pat_store.sv */
// Pattern character memory and per-slot pattern length table.
`timescale 1ns / 1ps
module gpbm_pat_store import gpbm_pkg::*; (
  input  logic            clk_i,
  input  pat_wr_t         wr_i,
  input  pat_rd_t         rd_i,
  output logic [7:0]      rdata_o,
  input  len_wr_t         len_wr_i,
  input  logic [SI_W-1:0] len_slot_i,
  output logic [PL_W-1:0] len_o
);

  logic [7:0]      mem_q [PATTERN_SLOTS*PATTERN_LEN];
  logic [PL_W-1:0] len_q [PATTERN_SLOTS];
  logic [7:0]      rdata_q;
  logic [PA_W-1:0] waddr, raddr;

  assign waddr = PA_W'(wr_i.slot) * PA_W'(PATTERN_LEN) + PA_W'(wr_i.idx);
  assign raddr = PA_W'(rd_i.slot) * PA_W'(PATTERN_LEN) + PA_W'(rd_i.idx);

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[waddr] <= wr_i.data;
    end
    rdata_q <= mem_q[raddr];
    if (len_wr_i.en) begin
      len_q[len_wr_i.slot] <= len_wr_i.len;
    end
  end

  assign rdata_o = rdata_q;
  assign len_o   = len_q[len_slot_i];

endmodule

/* design/gpbm_name_buf.sv */
// Basename character buffer with a registered read port.
`timescale 1ns / 1ps
module gpbm_name_buf import gpbm_pkg::*; (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [NI_W-1:0] waddr_i,
  input  logic [7:0]      wdata_i,
  input  logic [NI_W-1:0] raddr_i,
  output logic [7:0]      rdata_o
);

  logic [7:0] mem_q [NAME_LEN];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/gpbm_match_seq.sv */
// Sequencer that walks the glob match of the basename over the stored patterns in turn until one matches.
`timescale 1ns / 1ps
module gpbm_match_seq import gpbm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             fold_i,
  input  logic [CNT_W-1:0] count_i,
  input  logic [NL_W-1:0]  nl_i,
  input  logic             out_free_i,
  output pat_rd_t          prd_o,
  input  logic [7:0]       pdat_i,
  output logic [SI_W-1:0]  len_slot_o,
  input  logic [PL_W-1:0]  len_i,
  output logic [NI_W-1:0]  naddr_o,
  input  logic [7:0]       ndat_i,
  output seq_status_t      status_o
);

  typedef enum logic [18:0] {
    S_IDLE   = 19'h00001, S_START  = 19'h00002, S_LOOP  = 19'h00004,
    S_DEC    = 19'h00008, S_ESC    = 19'h00010, S_BANG  = 19'h00020,
    S_RB1    = 19'h00040, S_SCAN   = 19'h00080, S_UNT   = 19'h00100,
    S_ITEM   = 19'h00200, S_I0     = 19'h00400, S_I1    = 19'h00800,
    S_I2     = 19'h01000, S_CLSEND = 19'h02000, S_FAIL  = 19'h04000,
    S_TAIL   = 19'h08000, S_TCHK   = 19'h10000, S_NEXT  = 19'h20000,
    S_DONE   = 19'h40000
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] slot_q, slot_d;
  logic [PL_W-1:0]  p_q, p_d, sp_q, sp_d, pl_q, pl_d, cp_q, cp_d, ce_q, ce_d;
  logic [PL_W:0]    q_q, q_d;
  logic [NL_W-1:0]  n_q, n_d, sn_q, sn_d;
  logic [7:0]       nc_q, nc_d, c0_q, c0_d;
  logic             star_q, star_d, neg_q, neg_d, hit_q, hit_d, match_q, match_d;
  logic [PL_W-1:0]  ridx;
  logic [7:0]       pc, nc;
  logic [PL_W:0]    p1, p2, ncp, nce;
  logic [PL_W:0]    plw, cew;
  logic             done;

  assign pc  = fold(pdat_i, fold_i);
  assign nc  = fold(ndat_i, fold_i);
  assign p1  = (PL_W+1)'(p_q) + 1'b1;
  assign p2  = (PL_W+1)'(p_q) + 2'd2;
  assign plw = (PL_W+1)'(pl_q);
  assign cew = (PL_W+1)'(ce_q);

  assign prd_o.slot = slot_q[SI_W-1:0];
  assign prd_o.idx  = ridx[PI_W-1:0];
  assign len_slot_o = slot_q[SI_W-1:0];
  assign naddr_o    = n_q[NI_W-1:0];

  always_comb begin
    state_d = state_q;
    slot_d  = slot_q;  p_d  = p_q;  sp_d = sp_q;  pl_d = pl_q;
    cp_d    = cp_q;    ce_d = ce_q; q_d  = q_q;   n_d  = n_q;
    sn_d    = sn_q;    nc_d = nc_q; c0_d = c0_q;  star_d = star_q;
    neg_d   = neg_q;   hit_d = hit_q; match_d = match_q;
    ridx    = p_q;
    ncp     = '0;
    nce     = '0;
    done    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          slot_d  = '0;
          state_d = S_START;
        end
      end
      S_START: begin
        pl_d = len_i; p_d = '0; sp_d = '0; n_d = '0; sn_d = '0; star_d = 1'b0;
        state_d = S_LOOP;
      end
      S_LOOP: begin
        ridx = p_q;
        state_d = (n_q >= nl_i) ? S_TAIL : S_DEC;
      end
      S_DEC: begin
        nc_d = nc;
        if (p_q < pl_q && pc == CH_BSLASH && p1 < plw) begin
          ridx    = p1[PL_W-1:0];
          state_d = S_ESC;
        end else if (p_q < pl_q && pc == CH_LBRACK) begin
          cp_d  = p1[PL_W-1:0];
          neg_d = 1'b0;
          hit_d = 1'b0;
          if (p1 < plw) begin
            ridx    = p1[PL_W-1:0];
            state_d = S_BANG;
          end else begin
            state_d = S_UNT;
          end
        end else if (p_q < pl_q && pc == CH_STAR) begin
          p_d = p1[PL_W-1:0]; sp_d = p1[PL_W-1:0]; sn_d = n_q; star_d = 1'b1;
          state_d = S_LOOP;
        end else if (p_q < pl_q && (pc == CH_QUEST || pc == nc)) begin
          p_d = p1[PL_W-1:0]; n_d = n_q + 1'b1;
          state_d = S_LOOP;
        end else begin
          state_d = S_FAIL;
        end
      end
      S_ESC: begin
        if (pc == nc_q) begin
          p_d = p2[PL_W-1:0]; n_d = n_q + 1'b1;
          state_d = S_LOOP;
        end else begin
          state_d = S_FAIL;
        end
      end
      S_BANG: begin
        ncp   = (PL_W+1)'(cp_q) + ((pc == CH_BANG) ? 1'b1 : 1'b0);
        neg_d = (pc == CH_BANG);
        cp_d  = ncp[PL_W-1:0];
        ce_d  = ncp[PL_W-1:0];
        if (ncp < plw) begin
          ridx    = ncp[PL_W-1:0];
          state_d = S_RB1;
        end else begin
          state_d = S_UNT;
        end
      end
      S_RB1, S_SCAN: begin
        if (state_q == S_SCAN && pc == CH_RBRACK) begin
          q_d     = (PL_W+1)'(cp_q);
          state_d = S_ITEM;
        end else begin
          nce  = cew + ((state_q == S_SCAN || pc == CH_RBRACK) ? 1'b1 : 1'b0);
          ce_d = nce[PL_W-1:0];
          if (nce < plw) begin
            ridx    = nce[PL_W-1:0];
            state_d = S_SCAN;
          end else begin
            state_d = S_UNT;
          end
        end
      end
      S_UNT: begin
        if (nc_q == CH_LBRACK) begin
          p_d = p1[PL_W-1:0]; n_d = n_q + 1'b1;
          state_d = S_LOOP;
        end else begin
          state_d = S_FAIL;
        end
      end
      S_ITEM: begin
        ridx = q_q[PL_W-1:0];
        state_d = (q_q >= cew) ? S_CLSEND : S_I0;
      end
      S_I0: begin
        c0_d    = pc;
        ridx    = q_q[PL_W-1:0] + 1'b1;
        state_d = S_I1;
      end
      S_I1: begin
        if (pc == CH_DASH && (q_q + 2'd2) < cew) begin
          ridx    = q_q[PL_W-1:0] + 2'd2;
          state_d = S_I2;
        end else begin
          if (nc_q == c0_q) hit_d = 1'b1;
          q_d     = q_q + 1'b1;
          state_d = S_ITEM;
        end
      end
      S_I2: begin
        if (nc_q >= c0_q && nc_q <= pc) hit_d = 1'b1;
        q_d     = q_q + 2'd3;
        state_d = S_ITEM;
      end
      S_CLSEND: begin
        if (neg_q ^ hit_q) begin
          p_d = ce_q + 1'b1; n_d = n_q + 1'b1;
          state_d = S_LOOP;
        end else begin
          state_d = S_FAIL;
        end
      end
      S_FAIL: begin
        if (!star_q) begin
          state_d = S_NEXT;
        end else begin
          p_d  = sp_q;
          sn_d = sn_q + 1'b1;
          n_d  = sn_q + 1'b1;
          state_d = S_LOOP;
        end
      end
      S_TAIL: begin
        ridx = p_q;
        if (p_q >= pl_q) begin
          match_d = 1'b1;
          state_d = S_DONE;
        end else begin
          state_d = S_TCHK;
        end
      end
      S_TCHK: begin
        if (pc == CH_STAR) begin
          p_d     = p1[PL_W-1:0];
          state_d = S_TAIL;
        end else begin
          state_d = S_NEXT;
        end
      end
      S_NEXT: begin
        if ((slot_q + 1'b1) < count_i) begin
          slot_d  = slot_q + 1'b1;
          state_d = S_START;
        end else begin
          match_d = 1'b0;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free_i) begin
          done    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign status_o.done = done;
  assign status_o.busy = (state_q != S_IDLE);
  assign status_o.hit  = match_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;  p_q  <= p_d;  sp_q <= sp_d;  pl_q <= pl_d;
    cp_q   <= cp_d;    ce_q <= ce_d; q_q  <= q_d;   n_q  <= n_d;
    sn_q   <= sn_d;    nc_q <= nc_d; c0_q <= c0_d;  star_q <= star_d;
    neg_q  <= neg_d;   hit_q <= hit_d; match_q <= match_d;
  end

endmodule

/* design/glob_pattern_blocklist_match_unit.sv */
// Top level of the glob pattern blocklist match unit.
`timescale 1ns / 1ps
// Patterns are loaded one character item per cycle, while the input is ready,
// into a store of 32 slots of 32 characters, and a clear item empties the store.
// Path characters also load at one item per cycle while ready; each '/' or '\'
// separator restarts the kept basename. The final path character starts a match
// that walks the stored patterns with a single sequencer reading one pattern
// character per cycle from the pattern memory; patterns are tried in turn until
// one matches, with backtracking on '*'. Bracket classes are scanned
// character by character. The input is not ready while a match is running,
// and one result item appears per path. With case_fold set, ASCII letters
// are lowered before comparison.
// An empty or overlong basename gives no match without running the sequencer.
module glob_pattern_blocklist_match_unit import gpbm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic      cfg_data_i
);

  logic             fold_q;
  logic [CNT_W-1:0] count_q;
  logic [PL_W-1:0]  load_len_q;
  logic             load_ovf_q, dropped_q;
  logic [NL_W-1:0]  nlen_q;
  logic             ntl_q;
  logic             out_valid_q;
  out_item_t        out_q;

  logic             acc, out_free, is_sep, start, res_set;
  logic [NL_W-1:0]  nlen_n;
  logic             ntl_n, name_we, ovf_n;
  logic [PL_W-1:0]  load_len_n;
  pat_wr_t          pwr;
  pat_rd_t          prd;
  len_wr_t          lwr;
  logic [7:0]       pdat, ndat;
  logic [SI_W-1:0]  len_slot;
  logic [PL_W-1:0]  len_rd;
  logic [NI_W-1:0]  naddr;
  seq_status_t      st;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = !st.busy && out_free;
  assign acc        = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // Basename collection.
  assign is_sep = (in_data_i.ch == CH_SLASH) || (in_data_i.ch == CH_BSLASH);
  always_comb begin
    nlen_n  = nlen_q;
    ntl_n   = ntl_q;
    name_we = 1'b0;
    if (is_sep) begin
      nlen_n = '0;
      ntl_n  = 1'b0;
    end else if (nlen_q < NL_W'(NAME_LEN)) begin
      name_we = acc && (in_data_i.op == OP_PATH);
      nlen_n  = nlen_q + 1'b1;
    end else begin
      ntl_n = 1'b1;
    end
  end

  // Pattern loading.
  always_comb begin
    load_len_n = load_len_q;
    ovf_n      = load_ovf_q;
    pwr.en     = 1'b0;
    pwr.slot   = count_q[SI_W-1:0];
    pwr.idx    = load_len_q[PI_W-1:0];
    pwr.data   = in_data_i.ch;
    if (load_len_q < PL_W'(PATTERN_LEN)) begin
      pwr.en     = acc && (in_data_i.op == OP_PATTERN) &&
                   (count_q < CNT_W'(PATTERN_SLOTS));
      load_len_n = load_len_q + 1'b1;
    end else begin
      ovf_n = 1'b1;
    end
    lwr.slot = count_q[SI_W-1:0];
    lwr.len  = load_len_n;
    lwr.en   = acc && (in_data_i.op == OP_PATTERN) && in_data_i.last && !ovf_n &&
               (count_q < CNT_W'(PATTERN_SLOTS));
  end

  assign start = acc && (in_data_i.op == OP_PATH) && in_data_i.last && !ntl_n &&
                 (nlen_n != '0) && (count_q != '0);

  // A result item is produced either by a finished match or directly by a
  // final path character that needs no match.
  assign res_set = st.done ||
                   (acc && in_data_i.op == OP_PATH && in_data_i.last && !start);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fold_q      <= 1'b0;
      count_q     <= '0;
      load_len_q  <= '0;
      load_ovf_q  <= 1'b0;
      dropped_q   <= 1'b0;
      nlen_q      <= '0;
      ntl_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        fold_q <= cfg_data_i;
      end
      out_valid_q <= res_set || (out_valid_q && !out_ready_i);
      if (st.done) begin
        nlen_q      <= '0;
        ntl_q       <= 1'b0;
      end
      if (acc) begin
        case (in_data_i.op)
          OP_PATTERN: begin
            if (in_data_i.last) begin
              if (ovf_n || count_q >= CNT_W'(PATTERN_SLOTS)) begin
                dropped_q <= 1'b1;
              end else begin
                count_q <= count_q + 1'b1;
              end
              load_len_q <= '0;
              load_ovf_q <= 1'b0;
            end else begin
              load_len_q <= load_len_n;
              load_ovf_q <= ovf_n;
            end
          end
          OP_CLEAR: begin
            count_q    <= '0;
            load_len_q <= '0;
            load_ovf_q <= 1'b0;
            dropped_q  <= 1'b0;
          end
          OP_PATH: begin
            if (!in_data_i.last || start) begin
              // A running match still needs the basename length.
              nlen_q <= nlen_n;
              ntl_q  <= ntl_n;
            end else begin
              nlen_q      <= '0;
              ntl_q       <= 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (st.done) begin
      out_q.blocked         <= st.hit;
      out_q.name_overflow   <= 1'b0;
      out_q.pattern_dropped <= dropped_q;
    end else if (acc && in_data_i.op == OP_PATH && in_data_i.last && !start) begin
      out_q.blocked         <= 1'b0;
      out_q.name_overflow   <= ntl_n;
      out_q.pattern_dropped <= dropped_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  gpbm_pat_store u_pat_store (
    .clk_i      (clk_i),
    .wr_i       (pwr),
    .rd_i       (prd),
    .rdata_o    (pdat),
    .len_wr_i   (lwr),
    .len_slot_i (len_slot),
    .len_o      (len_rd)
  );

  gpbm_name_buf u_name_buf (
    .clk_i   (clk_i),
    .we_i    (name_we),
    .waddr_i (nlen_q[NI_W-1:0]),
    .wdata_i (in_data_i.ch),
    .raddr_i (naddr),
    .rdata_o (ndat)
  );

  gpbm_match_seq u_match_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .fold_i     (fold_q),
    .count_i    (count_q),
    .nl_i       (nlen_q),
    .out_free_i (out_free),
    .prd_o      (prd),
    .pdat_i     (pdat),
    .len_slot_o (len_slot),
    .len_i      (len_rd),
    .naddr_o    (naddr),
    .ndat_i     (ndat),
    .status_o   (st)
  );

  // A match never starts while another is running.
  assert property (@(posedge clk_i) disable iff (!rst_ni) start |-> !st.busy)
    else $error("match started while busy");

  // A finished match only lands when the output register is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni) st.done |-> out_free)
    else $error("match result overwrote a pending item");

  // An overlong basename never reports a match.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.blocked && out_data_o.name_overflow))
    else $error("blocked reported with name overflow");

  // Starting a match drops input ready in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) start |=> !in_ready_o)
    else $error("input ready during match");

endmodule
